### design/tbo_pkg.sv
package tbo_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_index_type;

endpackage

### design/tbo_front.sv
module tbo_front #(
   parameter int CW = tbo_pkg::COORD_WIDTH_DEFAULT,
   localparam int DW = CW + 1,
   localparam int NW = 2 * DW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic signed [CW-1:0] v_x [3],
   input  logic signed [CW-1:0] v_y [3],
   input  logic signed [CW-1:0] v_z [3],
   input  logic signed [CW-1:0] lo [3],
   input  logic signed [CW-1:0] hi [3],
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic                 out_sep,
   output logic signed [NW-1:0] out_n [3],
   output logic signed [DW-1:0] out_dl [3],
   output logic signed [DW-1:0] out_dh [3]
);
   import tbo_pkg::*;

   logic signed [CW-1:0] v_ff [3][3];
   logic signed [CW-1:0] v_in [3][3];
   logic                 s1_valid_ff;
   logic                 s2_valid_ff;
   logic                 s2_sep_ff;
   logic signed [NW-1:0] n_ff [3];
   logic signed [DW-1:0] dl_ff [3];
   logic signed [DW-1:0] dh_ff [3];
   logic signed [CW-1:0] lo_s1_ff [3];
   logic signed [CW-1:0] hi_s1_ff [3];
   logic                 adv1;
   logic                 adv2;
   logic                 sep_c;
   logic signed [NW-1:0] n_c [3];
   logic signed [DW-1:0] dl_c [3];
   logic signed [DW-1:0] dh_c [3];

   assign adv2 = !s2_valid_ff || !out_stall;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_stall = !adv1;
   assign out_valid = s2_valid_ff;
   assign out_sep = s2_sep_ff;
   assign out_n = n_ff;
   assign out_dl = dl_ff;
   assign out_dh = dh_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v_in[k][0] = v_x[k];
         v_in[k][1] = v_y[k];
         v_in[k][2] = v_z[k];
      end
   end

   // box axes, per-axis triangle normal and corner offsets relative to vertex 0
   always_comb begin
      logic signed [CW-1:0] tmin, tmax, bl, bh;
      logic signed [DW-1:0] p [3];
      logic signed [DW-1:0] q [3];
      sep_c = 1'b0;
      for (int i = 0; i < 3; i++) begin
         tmin = v_ff[0][i];
         tmax = v_ff[0][i];
         for (int k = 1; k < 3; k++) begin
            if (v_ff[k][i] < tmin) tmin = v_ff[k][i];
            if (v_ff[k][i] > tmax) tmax = v_ff[k][i];
         end
         bl = (lo_s1_ff[i] <= hi_s1_ff[i]) ? lo_s1_ff[i] : hi_s1_ff[i];
         bh = (lo_s1_ff[i] <= hi_s1_ff[i]) ? hi_s1_ff[i] : lo_s1_ff[i];
         if (tmax < bl || tmin > bh) sep_c = 1'b1;
         p[i] = DW'(v_ff[1][i]) - DW'(v_ff[0][i]);
         q[i] = DW'(v_ff[2][i]) - DW'(v_ff[0][i]);
         dl_c[i] = DW'(bl) - DW'(v_ff[0][i]);
         dh_c[i] = DW'(bh) - DW'(v_ff[0][i]);
      end
      n_c[0] = NW'(p[1] * q[2]) - NW'(p[2] * q[1]);
      n_c[1] = NW'(p[2] * q[0]) - NW'(p[0] * q[2]);
      n_c[2] = NW'(p[0] * q[1]) - NW'(p[1] * q[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
      if (adv1 && in_valid) begin
         v_ff <= v_in;
         lo_s1_ff <= lo;
         hi_s1_ff <= hi;
      end
      if (adv2 && s1_valid_ff) begin
         s2_sep_ff <= sep_c;
         n_ff <= n_c;
         dl_ff <= dl_c;
         dh_ff <= dh_c;
      end
   end

   // edge axes need the vertices and box again; the back end sees them through the queue
endmodule

### design/tbo_queue.sv
module tbo_queue #(
   parameter int W = 8,
   parameter int DEPTH = tbo_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [W-1:0] out_data
);
   import tbo_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

### design/tbo_back.sv
module tbo_back #(
   parameter int CW = tbo_pkg::COORD_WIDTH_DEFAULT,
   localparam int DW = CW + 1,
   localparam int NW = 2 * DW + 1,
   localparam int PW = NW + DW,
   localparam int SW = PW + 2,
   localparam int EW = CW + 2,
   localparam int AW = EW + CW + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic                 in_sep,
   input  logic signed [NW-1:0] in_n [3],
   input  logic signed [DW-1:0] in_dl [3],
   input  logic signed [DW-1:0] in_dh [3],
   input  logic signed [CW-1:0] in_v [3][3],
   input  logic signed [CW-1:0] in_lo [3],
   input  logic signed [CW-1:0] in_hi [3],
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic                 out_overlaps
);
   import tbo_pkg::*;

   logic                 s1_valid_ff, s2_valid_ff;
   logic                 s1_sep_ff, s2_ov_ff;
   logic signed [PW-1:0] pl_ff [3];
   logic signed [PW-1:0] ph_ff [3];
   logic                 nneg_ff [3];
   logic                 esep_ff;
   logic                 adv1, adv2;
   logic signed [PW-1:0] pl_c [3];
   logic signed [PW-1:0] ph_c [3];
   logic                 esep_c;
   logic                 nsep_c;

   assign adv2 = !s2_valid_ff || !out_stall;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_stall = !adv1;
   assign out_valid = s2_valid_ff;
   assign out_overlaps = s2_ov_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl_c[i] = PW'(in_n[i] * in_dl[i]);
         ph_c[i] = PW'(in_n[i] * in_dh[i]);
      end
   end

   // edge axes, each edge crossed with each box axis: axis component +/-e on two box axes, narrow dot products
   always_comb begin
      logic signed [EW-1:0] e [3][3];
      logic signed [CW-1:0] bl [3];
      logic signed [CW-1:0] bh [3];
      logic signed [AW-1:0] d, tmin, tmax, bmin, bmax, p, q;
      logic signed [EW-1:0] a [3];
      esep_c = 1'b0;
      for (int i = 0; i < 3; i++) begin
         bl[i] = (in_lo[i] <= in_hi[i]) ? in_lo[i] : in_hi[i];
         bh[i] = (in_lo[i] <= in_hi[i]) ? in_hi[i] : in_lo[i];
      end
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            e[i][k] = EW'(in_v[i][k]) - EW'(in_v[(i + 1) % 3][k]);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            a[j] = '0;
            a[(j + 1) % 3] = e[i][(j + 2) % 3];
            a[(j + 2) % 3] = -e[i][(j + 1) % 3];
            tmin = '0;
            tmax = '0;
            for (int k = 0; k < 3; k++) begin
               d = AW'(a[0] * in_v[k][0]) + AW'(a[1] * in_v[k][1])
                 + AW'(a[2] * in_v[k][2]);
               if (k == 0 || d < tmin) tmin = d;
               if (k == 0 || d > tmax) tmax = d;
            end
            bmin = '0;
            bmax = '0;
            for (int m = 0; m < 3; m++) begin
               p = AW'(a[m] * bl[m]);
               q = AW'(a[m] * bh[m]);
               bmin = bmin + ((p < q) ? p : q);
               bmax = bmax + ((p < q) ? q : p);
            end
            if (bmax < tmin || bmin > tmax) esep_c = 1'b1;
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] smin, smax;
      smin = '0;
      smax = '0;
      for (int i = 0; i < 3; i++) begin
         if (!nneg_ff[i]) begin
            smin = smin + SW'(pl_ff[i]);
            smax = smax + SW'(ph_ff[i]);
         end else begin
            smin = smin + SW'(ph_ff[i]);
            smax = smax + SW'(pl_ff[i]);
         end
      end
      nsep_c = (smax < 0) || (smin > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
      if (adv1 && in_valid) begin
         s1_sep_ff <= in_sep;
         pl_ff <= pl_c;
         ph_ff <= ph_c;
         esep_ff <= esep_c;
         for (int i = 0; i < 3; i++) nneg_ff[i] <= in_n[i][NW-1];
      end
      if (adv2 && s1_valid_ff) s2_ov_ff <= !(s1_sep_ff || esep_ff || nsep_c);
   end
endmodule

### design/triangle_box_overlap_test.sv
// triangle versus box overlap test, separating axes
// path: a request passes the front stages, the queue and the back stages; the response is registered
// throughput: one triangle per cycle while the response is not stalled, with two-stage front and back pipelines
// a two-entry queue between front and back absorbs response stalls
// reset (synchronous, active high) clears the box registers to zero and empties the pipe
module triangle_box_overlap_test #(
   parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_z,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_z,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_overlaps
);
   import tbo_pkg::*;
   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;
   localparam int QW = 1 + 3 * NW + 6 * DW + 15 * CW;

   logic signed [CW-1:0] lo_ff [3];
   logic signed [CW-1:0] hi_ff [3];
   logic signed [CW-1:0] vx [3];
   logic signed [CW-1:0] vy [3];
   logic signed [CW-1:0] vz [3];
   logic signed [CW-1:0] vq_ff [3][3];
   logic signed [CW-1:0] vq2_ff [3][3];
   logic signed [CW-1:0] lq_ff [3];
   logic signed [CW-1:0] hq_ff [3];
   logic signed [CW-1:0] lq2_ff [3];
   logic signed [CW-1:0] hq2_ff [3];
   logic                 f_valid, f_stall, f_sep;
   logic signed [NW-1:0] f_n [3];
   logic signed [DW-1:0] f_dl [3];
   logic signed [DW-1:0] f_dh [3];
   logic                 b_valid, b_stall, b_sep;
   logic signed [NW-1:0] b_n [3];
   logic signed [DW-1:0] b_dl [3];
   logic signed [DW-1:0] b_dh [3];
   logic signed [CW-1:0] b_v [3][3];
   logic signed [CW-1:0] b_lo [3];
   logic signed [CW-1:0] b_hi [3];
   logic [QW-1:0]        q_in, q_out;
   logic                 fadv1, fadv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_X: lo_ff[0] <= csr_data;
            REG_MIN_Y: lo_ff[1] <= csr_data;
            REG_MIN_Z: lo_ff[2] <= csr_data;
            REG_MAX_X: hi_ff[0] <= csr_data;
            REG_MAX_Y: hi_ff[1] <= csr_data;
            REG_MAX_Z: hi_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign vx = '{req_vertex0_x, req_vertex1_x, req_vertex2_x};
   assign vy = '{req_vertex0_y, req_vertex1_y, req_vertex2_y};
   assign vz = '{req_vertex0_z, req_vertex1_z, req_vertex2_z};

   tbo_front #(.CW(CW)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .v_x(vx), .v_y(vy), .v_z(vz), .lo(lo_ff), .hi(hi_ff),
      .out_valid(f_valid), .out_stall(f_stall), .out_sep(f_sep),
      .out_n(f_n), .out_dl(f_dl), .out_dh(f_dh)
   );

   // vertex and box copies ride alongside the front pipeline
   assign fadv1 = !req_stall;
   assign fadv2 = !f_valid || !f_stall;
   always_ff @(posedge clock) begin
      if (fadv1 && req_valid) begin
         for (int k = 0; k < 3; k++) begin
            vq_ff[k][0] <= vx[k];
            vq_ff[k][1] <= vy[k];
            vq_ff[k][2] <= vz[k];
         end
         lq_ff <= lo_ff;
         hq_ff <= hi_ff;
      end
      if (fadv2) begin
         vq2_ff <= vq_ff;
         lq2_ff <= lq_ff;
         hq2_ff <= hq_ff;
      end
   end

   always_comb begin
      q_in = {f_sep, f_n[0], f_n[1], f_n[2], f_dl[0], f_dl[1], f_dl[2],
              f_dh[0], f_dh[1], f_dh[2],
              vq2_ff[0][0], vq2_ff[0][1], vq2_ff[0][2],
              vq2_ff[1][0], vq2_ff[1][1], vq2_ff[1][2],
              vq2_ff[2][0], vq2_ff[2][1], vq2_ff[2][2],
              lq2_ff[0], lq2_ff[1], lq2_ff[2], hq2_ff[0], hq2_ff[1], hq2_ff[2]};
      {b_sep, b_n[0], b_n[1], b_n[2], b_dl[0], b_dl[1], b_dl[2],
       b_dh[0], b_dh[1], b_dh[2],
       b_v[0][0], b_v[0][1], b_v[0][2], b_v[1][0], b_v[1][1], b_v[1][2],
       b_v[2][0], b_v[2][1], b_v[2][2],
       b_lo[0], b_lo[1], b_lo[2], b_hi[0], b_hi[1], b_hi[2]} = q_out;
   end

   tbo_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(q_in),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(q_out)
   );

   tbo_back #(.CW(CW)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_stall(b_stall), .in_sep(b_sep),
      .in_n(b_n), .in_dl(b_dl), .in_dh(b_dh), .in_v(b_v), .in_lo(b_lo), .in_hi(b_hi),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_overlaps(rsp_overlaps)
   );
endmodule

### test/triangle_box_overlap_test_tb.sv
module triangle_box_overlap_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbo_pkg::*;

   localparam int W = 16;
   localparam int NUM_RANDOM = 2000;
   localparam int IDLE_LIMIT = 20000;

   typedef logic signed [W-1:0] coord_type;
   typedef struct {
      coord_type p[3][3];
   } tri_type;

   class overlap_scoreboard;
      longint box_lo[3];
      longint box_hi[3];
      bit     pending[$];
      int     mismatches;
      int     checked;
      int     hits;

      function void set_reg(reg_index_type idx, coord_type value);
         if (idx < REG_MAX_X) box_lo[idx] = value;
         else box_hi[idx - REG_MAX_X] = value;
      endfunction

      function bit predict_overlap(tri_type t);
         longint v[3][3];
         longint lo[3];
         longint hi[3];
         longint e[3];
         longint a[3];
         longint nrm[3];
         longint p[3];
         longint q[3];
         longint tmin;
         longint tmax;
         longint d;
         longint bmin;
         longint bmax;
         longint x;
         longint y;
         logic signed [127:0] smin;
         logic signed [127:0] smax;
         logic signed [127:0] pa;
         logic signed [127:0] pb;
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) v[k][i] = t.p[k][i];
         for (int i = 0; i < 3; i++) begin
            lo[i] = box_lo[i] <= box_hi[i] ? box_lo[i] : box_hi[i];
            hi[i] = box_lo[i] <= box_hi[i] ? box_hi[i] : box_lo[i];
         end
         // box axes
         for (int i = 0; i < 3; i++) begin
            tmin = v[0][i];
            tmax = v[0][i];
            for (int k = 1; k < 3; k++) begin
               if (v[k][i] < tmin) tmin = v[k][i];
               if (v[k][i] > tmax) tmax = v[k][i];
            end
            if (tmax < lo[i] || tmin > hi[i]) return 0;
         end
         // triangle normal
         for (int i = 0; i < 3; i++) begin
            p[i] = v[1][i] - v[0][i];
            q[i] = v[2][i] - v[0][i];
         end
         nrm[0] = p[1] * q[2] - p[2] * q[1];
         nrm[1] = p[2] * q[0] - p[0] * q[2];
         nrm[2] = p[0] * q[1] - p[1] * q[0];
         smin = 0;
         smax = 0;
         for (int i = 0; i < 3; i++) begin
            pa = 128'(signed'(nrm[i])) * 128'(signed'(lo[i] - v[0][i]));
            pb = 128'(signed'(nrm[i])) * 128'(signed'(hi[i] - v[0][i]));
            if (nrm[i] >= 0) begin
               smin += pa;
               smax += pb;
            end else begin
               smin += pb;
               smax += pa;
            end
         end
         if (smax < 0 || smin > 0) return 0;
         // edge cross box axes
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) e[c] = v[i][c] - v[(i + 1) % 3][c];
            for (int j = 0; j < 3; j++) begin
               a[0] = (j == 2 ? e[1] : 0) - (j == 1 ? e[2] : 0);
               a[1] = (j == 0 ? e[2] : 0) - (j == 2 ? e[0] : 0);
               a[2] = (j == 1 ? e[0] : 0) - (j == 0 ? e[1] : 0);
               for (int k = 0; k < 3; k++) begin
                  d = a[0] * v[k][0] + a[1] * v[k][1] + a[2] * v[k][2];
                  if (k == 0 || d < tmin) tmin = d;
                  if (k == 0 || d > tmax) tmax = d;
               end
               bmin = 0;
               bmax = 0;
               for (int c = 0; c < 3; c++) begin
                  x = a[c] * lo[c];
                  y = a[c] * hi[c];
                  bmin += x < y ? x : y;
                  bmax += x < y ? y : x;
               end
               if (bmax < tmin || bmin > tmax) return 0;
            end
         end
         return 1;
      endfunction

      function void note_triangle(tri_type t);
         pending.insert(pending.size(), predict_overlap(t));
      endfunction

      function void check_overlaps(logic got);
         bit want;
         if (pending.size() == 0) begin
            $error("overlaps: beat with nothing expected, actual %0b", got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want) hits++;
         if (got !== want) begin
            $error("overlaps: expected %0b, actual %0b", want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic   clock = 0;
   logic   reset = 1;
   logic   csr_write = 0;
   logic   [2:0] csr_index = '0;
   logic   [W-1:0] csr_data = '0;
   logic   req_valid = 0;
   logic   req_stall;
   coord_type vin[3][3];
   logic   rsp_valid;
   logic   rsp_stall = 1;
   logic   rsp_overlaps;

   overlap_scoreboard sb = new();
   bit     long_hold = 0;
   int     idle_cycles = 0;

   initial for (int k = 0; k < 3; k++) for (int i = 0; i < 3; i++) vin[k][i] = '0;

   always #4 clock = ~clock;

   triangle_box_overlap_test #(.COORD_WIDTH(W)) u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex0_x(vin[0][0]), .req_vertex0_y(vin[0][1]), .req_vertex0_z(vin[0][2]),
      .req_vertex1_x(vin[1][0]), .req_vertex1_y(vin[1][1]), .req_vertex1_z(vin[1][2]),
      .req_vertex2_x(vin[2][0]), .req_vertex2_y(vin[2][1]), .req_vertex2_z(vin[2][2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_overlaps(rsp_overlaps)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic coord_type near_coord(coord_type base, int spread);
      longint x;
      x = longint'(base) + $urandom_range(0, 2 * spread) - spread;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      return coord_type'(x);
   endfunction

   task automatic write_reg(reg_index_type idx, coord_type value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz);
      write_reg(REG_MIN_X, coord_type'(lx));
      write_reg(REG_MIN_Y, coord_type'(ly));
      write_reg(REG_MIN_Z, coord_type'(lz));
      write_reg(REG_MAX_X, coord_type'(hx));
      write_reg(REG_MAX_Y, coord_type'(hy));
      write_reg(REG_MAX_Z, coord_type'(hz));
      csr_write <= 0;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_triangle(tri_type t, bit with_gaps);
      int g;
      g = with_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      for (int k = 0; k < 3; k++) for (int i = 0; i < 3; i++) vin[k][i] <= t.p[k][i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_triangle(t);
   endtask

   function automatic tri_type random_triangle(bit near_box);
      tri_type t;
      coord_type c[3];
      int spread;
      spread = $urandom_range(0, 3) == 0 ? 20000 : $urandom_range(1, 600);
      for (int i = 0; i < 3; i++) begin
         if (near_box)
            c[i] = near_coord(coord_type'(sb.box_lo[i] + (sb.box_hi[i] - sb.box_lo[i]) / 2),
                              800);
         else c[i] = coord_type'($urandom);
      end
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            t.p[k][i] = near_box ? near_coord(c[i], spread) : coord_type'($urandom);
      return t;
   endfunction

   function automatic tri_type make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2);
      tri_type t;
      t.p[0] = '{coord_type'(a0), coord_type'(a1), coord_type'(a2)};
      t.p[1] = '{coord_type'(b0), coord_type'(b1), coord_type'(b2)};
      t.p[2] = '{coord_type'(c0), coord_type'(c1), coord_type'(c2)};
      return t;
   endfunction

   // receiver side
   initial begin
      int g;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (60) @(posedge clock);
            long_hold = 0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_stall <= 1;
            repeat (g) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_overlaps(rsp_overlaps);
      if (!reset && ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      tri_type t;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: box at reset (a point at origin), then a small box
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1), 0);
      wait_drained();
      set_box(-100, -100, -100, 100, 100, 100);
      send_triangle(make_tri(-50, 0, 0, 50, 0, 0, 0, 50, 0), 0);
      // touching faces
      send_triangle(make_tri(100, 0, 0, 200, 0, 0, 150, 50, 0), 0);
      send_triangle(make_tri(101, 0, 0, 200, 0, 0, 150, 50, 0), 0);
      // normal axis: plane touching the box corner, then plane cutting through the box
      send_triangle(make_tri(300, 0, 0, 0, 300, 0, 0, 0, 300), 0);
      send_triangle(make_tri(200, 0, 0, 0, 200, 0, 0, 0, 200), 0);
      // separated by the x box axis, then separated only by an edge axis
      send_triangle(make_tri(150, 150, -500, 150, 150, 500, 250, 50, 0), 0);
      send_triangle(make_tri(0, 250, 0, 250, 0, 0, 250, 250, 0), 0);
      // collinear, ordinary and single-point triangles, then a full-range triangle
      send_triangle(make_tri(-300, -300, -300, 0, 0, 0, 300, 300, 300), 0);
      send_triangle(make_tri(-300, -300, 300, 0, 0, 0, 300, 300, 300), 0);
      send_triangle(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5), 0);
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                             32767, -32768, 0), 0);
      wait_drained();
      // extremes: full range box, inverted box
      set_box(-32768, -32768, -32768, 32767, 32767, 32767);
      send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                             -32768, 32767, 32767), 0);
      send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, -32768,
                             32767, -32768, 32767), 0);
      wait_drained();
      set_box(32767, 10, 32767, -32768, -10, -32768);
      send_triangle(make_tri(0, 20, 0, 5, 30, 5, -5, 40, 9), 0);
      send_triangle(make_tri(0, 10, 0, 5, 30, 5, -5, 40, 9), 0);
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                             -32768, 32767, -32768), 0);
      wait_drained();

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 250 == 0) begin
            wait_drained();
            case ($urandom_range(0, 3))
               0: set_box(-32768, -32768, -32768, 32767, 32767, 32767);
               1: set_box(coord_type'($urandom), coord_type'($urandom),
                          coord_type'($urandom), coord_type'($urandom),
                          coord_type'($urandom), coord_type'($urandom));
               default: begin
                  coord_type cx, cy, cz;
                  cx = coord_type'($urandom_range(0, 40000) - 20000);
                  cy = coord_type'($urandom_range(0, 40000) - 20000);
                  cz = coord_type'($urandom_range(0, 40000) - 20000);
                  set_box(cx, cy, cz, near_coord(cx, 2000), near_coord(cy, 2000),
                          near_coord(cz, 2000));
               end
            endcase
         end
         if (n == 700) long_hold = 1;
         if (n == 1200) wait_drained();
         t = random_triangle($urandom_range(0, 9) != 0);
         send_triangle(t, !(n >= 500 && n < 700) && !(n >= 700 && n < 760));
      end
      wait_drained();
      $display("covered %0d triangles, %0d overlapping, box reprogrammed every 250",
               sb.checked, sb.hits);
      if (sb.mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
